/* rtl/core/tpot_pkg.sv */
package tpot_pkg;

   // Event kinds carried in req_tuser
   typedef enum logic [1:0] {
      EV_ABS_X = 2'd0,
      EV_ABS_Y = 2'd1,
      EV_TOUCH = 2'd2,
      EV_OTHER = 2'd3
   } event_code_type;

   // Display rotation
   typedef enum logic [1:0] {
      ORIENT_0   = 2'd0,
      ORIENT_90  = 2'd1,
      ORIENT_180 = 2'd2,
      ORIENT_270 = 2'd3
   } orient_type;

   // Configuration register indexes
   localparam logic [2:0] CSR_SWAP_AXES   = 3'd0;
   localparam logic [2:0] CSR_MIRROR_X    = 3'd1;
   localparam logic [2:0] CSR_MIRROR_Y    = 3'd2;
   localparam logic [2:0] CSR_ORIENTATION = 3'd3;
   localparam logic [2:0] CSR_WIDTH       = 3'd4;
   localparam logic [2:0] CSR_HEIGHT      = 3'd5;

   localparam int RES_W   = 15;
   localparam int VALUE_W = 16;

   localparam logic [RES_W-1:0] WIDTH_RESET  = 15'd320;
   localparam logic [RES_W-1:0] HEIGHT_RESET = 15'd240;

   typedef struct packed {
      logic             swap_axes;
      logic             mirror_x;
      logic             mirror_y;
      orient_type       orientation;
      logic [RES_W-1:0] width_pixels;
      logic [RES_W-1:0] height_pixels;
   } cfg_type;

endpackage

/* rtl/core/touch_point_orientation_transform_top.sv */
// Touch point orientation transform. Takes one touch event word per clock,
// unless a tlast word waits on a stalled result (X, Y, touch on/off or an
// ignored code; tlast closes a report frame), and latches a pending point.
// Each tlast word produces one result word: the pending point swapped,
// mirrored, rotated and clamped to the display, also written back as the new
// pending point. A word goes into the input register, its result into the
// result register; the single transform stage updates the pending point in
// the same cycle it produces the result. Configuration writes are taken at
// any time but are meant to be made while no words are in flight.
module touch_point_orientation_transform_top #(
   parameter int COORD_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] event_value (signed)
   input  logic [1:0]  req_tuser,   // [1:0] event_code
   input  logic        req_tlast,   // sync_mark
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [14:0] point_x_out, [29:15] point_y_out,
                                    // [30] pressed_out, [31] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [14:0] csr_data
);

   localparam int EW = (COORD_WIDTH > 16) ? COORD_WIDTH : 16;

   tpot_pkg::cfg_type cfg_ff, cfg_in;

   logic                          s1_valid_ff, s1_valid_in;
   tpot_pkg::event_code_type      s1_code_ff;
   logic [15:0]                   s1_value_ff;
   logic                          s1_sync_ff;

   logic signed [COORD_WIDTH-1:0] pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;
   logic                          pend_pressed_ff, pend_pressed_in;

   logic                          out_valid_ff, out_valid_in;
   logic [tpot_pkg::RES_W-1:0]    out_x_ff, out_y_ff;
   logic                          out_pressed_ff;

   logic                          out_free, s1_fire, req_take, emit;
   logic [EW-1:0]                 value_ext;
   logic signed [COORD_WIDTH-1:0] cur_x, cur_y;
   logic [tpot_pkg::RES_W-1:0]    new_x, new_y;
   logic [EW-1:0]                 new_x_ext, new_y_ext;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            tpot_pkg::CSR_SWAP_AXES:   cfg_in.swap_axes = csr_data[0];
            tpot_pkg::CSR_MIRROR_X:    cfg_in.mirror_x = csr_data[0];
            tpot_pkg::CSR_MIRROR_Y:    cfg_in.mirror_y = csr_data[0];
            tpot_pkg::CSR_ORIENTATION:
               cfg_in.orientation = tpot_pkg::orient_type'(csr_data[1:0]);
            tpot_pkg::CSR_WIDTH:       cfg_in.width_pixels = csr_data;
            tpot_pkg::CSR_HEIGHT:      cfg_in.height_pixels = csr_data;
            default: ;
         endcase
      end
   end

   // Handshake: a non-sync word always retires; a sync word needs the result slot.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && (!s1_sync_ff || out_free);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_take   = req_tvalid && req_tready;
   assign emit       = s1_fire && s1_sync_ff;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_fire);
   assign out_valid_in = emit || (out_valid_ff && !rsp_tready);

   // Latch the event, then transform from the updated pending point.
   assign value_ext = {{(EW-16){s1_value_ff[15]}}, s1_value_ff};
   always_comb begin
      cur_x = pend_x_ff;
      cur_y = pend_y_ff;
      pend_pressed_in = pend_pressed_ff;
      case (s1_code_ff)
         tpot_pkg::EV_ABS_X: cur_x = value_ext[COORD_WIDTH-1:0];
         tpot_pkg::EV_ABS_Y: cur_y = value_ext[COORD_WIDTH-1:0];
         tpot_pkg::EV_TOUCH: pend_pressed_in = (s1_value_ff != '0);
         default: ;
      endcase
   end

   tpot_xform #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_xform (
      .cfg   (cfg_ff),
      .x_in  (cur_x),
      .y_in  (cur_y),
      .x_out (new_x),
      .y_out (new_y)
   );

   assign new_x_ext = {{(EW-tpot_pkg::RES_W){1'b0}}, new_x};
   assign new_y_ext = {{(EW-tpot_pkg::RES_W){1'b0}}, new_y};
   assign pend_x_in = s1_sync_ff ? new_x_ext[COORD_WIDTH-1:0] : cur_x;
   assign pend_y_in = s1_sync_ff ? new_y_ext[COORD_WIDTH-1:0] : cur_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.swap_axes     <= 1'b0;
         cfg_ff.mirror_x      <= 1'b0;
         cfg_ff.mirror_y      <= 1'b0;
         cfg_ff.orientation   <= tpot_pkg::ORIENT_0;
         cfg_ff.width_pixels  <= tpot_pkg::WIDTH_RESET;
         cfg_ff.height_pixels <= tpot_pkg::HEIGHT_RESET;
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         pend_x_ff       <= '0;
         pend_y_ff       <= '0;
         pend_pressed_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_fire) begin
            pend_x_ff       <= pend_x_in;
            pend_y_ff       <= pend_y_in;
            pend_pressed_ff <= pend_pressed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_code_ff  <= tpot_pkg::event_code_type'(req_tuser);
         s1_value_ff <= req_tdata;
         s1_sync_ff  <= req_tlast;
      end
      if (emit) begin
         out_x_ff       <= new_x;
         out_y_ff       <= new_y;
         out_pressed_ff <= pend_pressed_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_pressed_ff, out_y_ff, out_x_ff};

endmodule

/* rtl/core/tpot_xform.sv */
// Swap, mirror, rotate and clamp of one pending point.
module tpot_xform #(
   parameter int COORD_WIDTH = 16
) (
   input  tpot_pkg::cfg_type                cfg,
   input  logic signed [COORD_WIDTH-1:0]    x_in,
   input  logic signed [COORD_WIDTH-1:0]    y_in,
   output logic [tpot_pkg::RES_W-1:0]       x_out,
   output logic [tpot_pkg::RES_W-1:0]       y_out
);

   // wide enough for coordinate plus two resolution offsets
   localparam int AW = ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) + 2;

   logic signed [AW-1:0] w, h, xs, ys, x0, y0, x1, y1, x2, y2;
   logic                 upright;

   assign w = signed'({{(AW-tpot_pkg::RES_W){1'b0}}, cfg.width_pixels});
   assign h = signed'({{(AW-tpot_pkg::RES_W){1'b0}}, cfg.height_pixels});
   assign xs = {{(AW-COORD_WIDTH){x_in[COORD_WIDTH-1]}}, x_in};
   assign ys = {{(AW-COORD_WIDTH){y_in[COORD_WIDTH-1]}}, y_in};
   assign upright = (cfg.orientation == tpot_pkg::ORIENT_0) ||
                    (cfg.orientation == tpot_pkg::ORIENT_180);

   always_comb begin
      x0 = cfg.swap_axes ? ys : xs;
      y0 = cfg.swap_axes ? xs : ys;
      x1 = cfg.mirror_x ? ((upright ? w : h) - x0) : x0;
      y1 = cfg.mirror_y ? ((upright ? h : w) - y0) : y0;
      case (cfg.orientation)
         tpot_pkg::ORIENT_90: begin
            x2 = y1;
            y2 = h - x1;
         end
         tpot_pkg::ORIENT_180: begin
            x2 = w - x1;
            y2 = h - y1;
         end
         tpot_pkg::ORIENT_270: begin
            x2 = w - y1;
            y2 = x1;
         end
         default: begin
            x2 = x1;
            y2 = y1;
         end
      endcase
   end

   always_comb begin
      if (x2 <= 0) begin
         x_out = '0;
      end else if (x2 >= w) begin
         x_out = (cfg.width_pixels == '0) ? '0 : cfg.width_pixels - 1'b1;
      end else begin
         x_out = x2[tpot_pkg::RES_W-1:0];
      end
      if (y2 <= 0) begin
         y_out = '0;
      end else if (y2 >= h) begin
         y_out = (cfg.height_pixels == '0) ? '0 : cfg.height_pixels - 1'b1;
      end else begin
         y_out = y2[tpot_pkg::RES_W-1:0];
      end
   end

endmodule

/* rtl/core/tpot_checker.sv */
module tpot_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        csr_ready
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // a fresh result comes from a frame-closing word taken through the input register
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tlast, 2))
      else $error("result without a frame-closing word");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[31] == 1'b0) && csr_ready)
      else $error("result pad bit set or config port blocked");

endmodule

bind touch_point_orientation_transform_top tpot_checker u_tpot_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_ready  (csr_ready)
);
